### hw/rtl/uat_pkg.sv
// ----------------------------------------------------------------------------
// uat_pkg
// Shared constants and types for the card ID allowlist table.
// ----------------------------------------------------------------------------
package uat_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 6;
    localparam int ID_W     = 32;
    localparam int POS_W    = 5;
    localparam int CMD_W    = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    // what enters the tail cell on a shift
    localparam logic [1:0] PUSH_HEAD = 2'd0;  // recirculate entry leaving the head
    localparam logic [1:0] PUSH_NEXT = 2'd1;  // skip head, recirculate its neighbor
    localparam logic [1:0] PUSH_KEY  = 2'd2;  // append the command's ID

    typedef struct packed {
        logic       shift;
        logic [1:0] push_sel;
    } ring_ctrl_t;

endpackage

### hw/rtl/uat_cell.sv
// ----------------------------------------------------------------------------
// uat_cell
// One entry of the ring: holds an ID, passes it on when shifted, and flags
// a match against the search key.
// ----------------------------------------------------------------------------
module uat_cell (
    input  logic                    clk,
    input  logic                    shift,
    input  logic [uat_pkg::ID_W-1:0] d,
    input  logic [uat_pkg::ID_W-1:0] key,
    output logic [uat_pkg::ID_W-1:0] q,
    output logic                    hit
);

    logic [uat_pkg::ID_W-1:0] entry_reg;
    logic [uat_pkg::ID_W-1:0] entry_next;

    assign entry_next = shift ? d : entry_reg;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q   = entry_reg;
    assign hit = (entry_reg == key);

endmodule

### hw/rtl/uat_ring.sv
// ----------------------------------------------------------------------------
// uat_ring
// Circular chain of entry cells. Each shift moves every entry one cell
// toward the head; the tail takes the selected push word.
// ----------------------------------------------------------------------------
module uat_ring (
    input  logic                     clk,
    input  uat_pkg::ring_ctrl_t      ctrl,
    input  logic [uat_pkg::ID_W-1:0] key,
    output logic [uat_pkg::ID_W-1:0] head_data,
    output logic                     head_hit
);

    localparam int NEXT_IDX = 1 % uat_pkg::CAPACITY;

    logic [uat_pkg::ID_W-1:0] q_arr   [uat_pkg::CAPACITY];
    logic                     hit_arr [uat_pkg::CAPACITY];
    logic [uat_pkg::ID_W-1:0] push_val;

    always_comb
    begin
        unique case (ctrl.push_sel)
            uat_pkg::PUSH_HEAD: push_val = q_arr[0];
            uat_pkg::PUSH_NEXT: push_val = q_arr[NEXT_IDX];
            uat_pkg::PUSH_KEY:  push_val = key;
            default:            push_val = q_arr[0];
        endcase
    end

    for (genvar i = 0; i < uat_pkg::CAPACITY; i++)
    begin : g_cell
        logic [uat_pkg::ID_W-1:0] d_in;
        if (i == uat_pkg::CAPACITY - 1)
        begin : g_tail
            assign d_in = push_val;
        end
        else
        begin : g_mid
            assign d_in = q_arr[i+1];
        end

        uat_cell u_cell (
            .clk   (clk),
            .shift (ctrl.shift),
            .d     (d_in),
            .key   (key),
            .q     (q_arr[i]),
            .hit   (hit_arr[i])
        );
    end

    assign head_data = q_arr[0];
    assign head_hit  = hit_arr[0];

endmodule

### hw/rtl/uid_allowlist_table_top.sv
// ----------------------------------------------------------------------------
// uid_allowlist_table_top
// Ordered allowlist of up to 32 card IDs with lookup, add, remove (with
// compaction), clear and indexed read. One result word per command word.
// ----------------------------------------------------------------------------
// The list lives in a ring of 32 cells that rotates one cell per cycle past
// the head while a command scans; only the head cell's match flag is used.
// Lookup, add, remove and read each take one full rotation, then load the
// result into the output slot once it is free; clear and unused command
// codes skip the rotation. A new command word is accepted only after the
// load. Remove closes the gap during the same rotation by feeding the head's
// neighbor back into the tail, and add appends by feeding the new ID into
// the tail when the slot at the current count passes the head. The list is
// empty after reset; unused codes leave it unchanged and answer ok = 0.
// ----------------------------------------------------------------------------
module uid_allowlist_table_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // card_id[31:0], position[36:32], zero pad[39:37]
    input  logic [2:0]  s_tuser,   // command[2:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // ok[0], read_id[32:1], entries_used[38:33], pad[39]
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [uat_pkg::IDX_W-1:0]    step_reg,  step_next;
    logic [uat_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         found_reg, found_next;   // match seen (or removed)
    logic                         added_reg, added_next;
    logic                         ok_reg,    ok_next;
    logic [uat_pkg::ID_W-1:0]     rid_reg,   rid_next;

    // latched command
    logic [uat_pkg::CMD_W-1:0]    cmd_reg,   cmd_next;
    logic [uat_pkg::ID_W-1:0]     key_reg,   key_next;
    logic [uat_pkg::POS_W-1:0]    pos_reg,   pos_next;

    // output slot
    logic                         mv_reg,    mv_next;
    logic [39:0]                  md_reg,    md_next;

    uat_pkg::ring_ctrl_t          ring_ctrl;
    logic [uat_pkg::ID_W-1:0]     head_data;
    logic                         head_hit;

    uat_ring u_ring (
        .clk       (clk),
        .ctrl      (ring_ctrl),
        .key       (key_reg),
        .head_data (head_data),
        .head_hit  (head_hit)
    );

    logic                         s_fire;
    logic                         slot_free;
    logic [uat_pkg::CNT_W-1:0]    step_ext;
    logic                         in_list;      // head holds a live entry
    logic                         last_step;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign slot_free = !mv_reg || m_tready;
    assign step_ext  = uat_pkg::CNT_W'(step_reg);
    assign in_list   = (step_ext < count_reg);
    assign last_step = (step_reg == uat_pkg::IDX_W'(uat_pkg::CAPACITY - 1));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        count_next = count_reg;
        found_next = found_reg;
        added_next = added_reg;
        ok_next    = ok_reg;
        rid_next   = rid_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        ring_ctrl.shift    = 1'b0;
        ring_ctrl.push_sel = uat_pkg::PUSH_HEAD;

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    cmd_next   = s_tuser;
                    key_next   = s_tdata[31:0];
                    pos_next   = s_tdata[36:32];
                    step_next  = '0;
                    found_next = 1'b0;
                    added_next = 1'b0;
                    rid_next   = '0;
                    ok_next    = 1'b0;
                    unique case (s_tuser)
                        uat_pkg::CMD_LOOKUP,
                        uat_pkg::CMD_ADD,
                        uat_pkg::CMD_REMOVE,
                        uat_pkg::CMD_READ:
                        begin
                            state_next = ST_SCAN;
                        end
                        uat_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            ok_next    = 1'b1;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                ring_ctrl.shift = 1'b1;
                if (in_list && head_hit)
                begin
                    found_next = 1'b1;
                end

                unique case (cmd_reg)
                    uat_pkg::CMD_REMOVE:
                    begin
                        // once the first match has passed, every entry moves down
                        if (found_reg || (in_list && head_hit))
                        begin
                            ring_ctrl.push_sel = uat_pkg::PUSH_NEXT;
                        end
                    end
                    uat_pkg::CMD_ADD:
                    begin
                        // all live entries have passed by the time the append slot arrives
                        if (step_ext == count_reg && !found_reg)
                        begin
                            ring_ctrl.push_sel = uat_pkg::PUSH_KEY;
                            added_next         = 1'b1;
                        end
                    end
                    uat_pkg::CMD_READ:
                    begin
                        if (step_ext == uat_pkg::CNT_W'(pos_reg) && in_list)
                        begin
                            rid_next = head_data;
                            ok_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                step_next = step_reg + 1'b1;

                if (last_step)
                begin
                    state_next = ST_DONE;
                    unique case (cmd_reg)
                        uat_pkg::CMD_LOOKUP:
                        begin
                            ok_next = found_next;
                        end
                        uat_pkg::CMD_ADD:
                        begin
                            ok_next = found_next || added_next;
                            if (added_next)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        uat_pkg::CMD_REMOVE:
                        begin
                            ok_next = found_next;
                            if (found_next)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_DONE:
            begin
                if (slot_free)
                begin
                    mv_next    = 1'b1;
                    md_next    = {1'b0, count_reg, rid_reg, ok_reg};
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
    end

    // payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        found_reg <= found_next;
        added_reg <= added_next;
        ok_reg    <= ok_next;
        rid_reg   <= rid_next;
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        pos_reg   <= pos_next;
        md_reg    <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for uid_allowlist_table_top. Command words go in on
// the slave stream, and a shadow copy of the ID list predicts every reply
// word, which is compared field by field with what comes out. Both stream
// sides idle in random bursts until the closing stretch of the run.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // first of the unused command codes; everything above CMD_READ is spare
    localparam logic [uat_pkg::CMD_W-1:0] CMD_SPARE_FIRST = uat_pkg::CMD_READ + 3'd1;
    localparam logic [uat_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam int POOL_SIZE   = 40;     // IDs reused so lookups and removes hit
    localparam int RANDOM_GOAL = 410;    // random words after the directed part
    localparam int QUIET_TAIL  = 80;     // last words go without any idling
    localparam int DRAIN_WAIT  = 40;     // one rotation plus margin
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic [uat_pkg::CMD_W-1:0] cmd;
        logic [uat_pkg::ID_W-1:0]  card;
        logic [uat_pkg::POS_W-1:0] pos;
    } cmd_word_t;

    typedef struct {
        logic                      ok;
        logic [uat_pkg::ID_W-1:0]  read_id;
        logic [uat_pkg::CNT_W-1:0] used;
    } reply_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // card_id[31:0], position[36:32], zero pad[39:37]
    logic [2:0]  s_tuser  = '0;   // command[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // ok[0], read_id[32:1], entries_used[38:33], pad[39]

    uid_allowlist_table_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock; reset held low from the start, released on a falling edge
    initial
    begin
        fork
            forever #2 clk = ~clk;
            begin
                repeat (7) @(posedge clk);
                @(negedge clk);
                rst_n <= 1'b1;
            end
        join
    end

    // ------------------------------------------------------------------------
    // Shadow of the list and the reply predictor
    // ------------------------------------------------------------------------
    logic [uat_pkg::ID_W-1:0] shadow_ids [uat_pkg::CAPACITY];
    int                       shadow_count = 0;

    reply_t    expected_replies [$];
    cmd_word_t pending_words [$];

    // Applies one command word to the shadow list and returns the reply.
    function automatic reply_t allowlist_apply(input logic [uat_pkg::CMD_W-1:0] cmd,
                                               input logic [uat_pkg::ID_W-1:0]  card,
                                               input logic [uat_pkg::POS_W-1:0] pos);
        reply_t r;
        int     hit;
        r.ok      = 1'b0;
        r.read_id = '0;
        hit       = -1;
        // first match only; entries past the count are stale and never seen
        for (int k = 0; k < shadow_count; k++)
            if (hit < 0 && shadow_ids[k] == card)
                hit = k;
        case (cmd)
            uat_pkg::CMD_LOOKUP:
                r.ok = (hit >= 0);
            uat_pkg::CMD_ADD:
            begin
                if (hit >= 0)
                    r.ok = 1'b1;
                else if (shadow_count < uat_pkg::CAPACITY)
                begin
                    shadow_ids[shadow_count] = card;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            uat_pkg::CMD_REMOVE:
            begin
                if (hit >= 0)
                begin
                    // compaction: later entries slide down one slot
                    for (int k = hit + 1; k < shadow_count; k++)
                        shadow_ids[k-1] = shadow_ids[k];
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            uat_pkg::CMD_CLEAR:
            begin
                shadow_count = 0;
                r.ok = 1'b1;
            end
            uat_pkg::CMD_READ:
            begin
                if (int'(pos) < shadow_count)
                begin
                    r.read_id = shadow_ids[pos];
                    r.ok = 1'b1;
                end
            end
            default: ;  // spare codes: no change, ok = 0
        endcase
        r.used = shadow_count[uat_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic queue_word(input logic [uat_pkg::CMD_W-1:0] cmd,
                              input logic [uat_pkg::ID_W-1:0]  card,
                              input logic [uat_pkg::POS_W-1:0] pos);
        cmd_word_t w;
        w.cmd  = cmd;
        w.card = card;
        w.pos  = pos;
        pending_words.push_back(w);
    endtask

    // ------------------------------------------------------------------------
    // Bookkeeping shared by driver and monitor
    // ------------------------------------------------------------------------
    int   total_words  = 0;
    int   words_taken  = 0;
    int   mismatches   = 0;
    int   cycle_count  = 0;
    bit   word_taken   = 1'b0;  // slave handshake seen at the last rising edge
    bit   quiet;                // closing stretch: no idling on either side
    int   send_gap     = 0;
    int   stall_left   = 0;

    assign quiet = (total_words > 0) && (words_taken >= total_words - QUIET_TAIL);

    // ------------------------------------------------------------------------
    // Driver: falling edge. A word stays up until a rising edge takes it;
    // between words a random gap may be inserted.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        cmd_word_t w;
        if (rst_n)
        begin
            if (!s_tvalid || word_taken)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap--;
                end
                else if (pending_words.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 7) == 0)
                    begin
                        s_tvalid <= 1'b0;
                        send_gap = $urandom_range(1, 16) - 1;
                    end
                    else
                    begin
                        w = pending_words.pop_front();
                        s_tdata  <= {3'b000, w.pos, w.card};
                        s_tuser  <= w.cmd;
                        s_tvalid <= 1'b1;
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end

            // receiver back-pressure in bursts
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: rising edge. Predict on each accepted command word first, so a
    // reply taken at the same edge already has its expectation queued.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        reply_t want;
        reply_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else if (rst_n)
        begin
            word_taken = s_tvalid && s_tready;
            if (word_taken)
            begin
                expected_replies.push_back(
                    allowlist_apply(s_tuser, s_tdata[31:0], s_tdata[36:32]));
                words_taken++;
            end

            if (m_tvalid && m_tready)
            begin
                got.ok      = m_tdata[0];
                got.read_id = m_tdata[32:1];
                got.used    = m_tdata[38:33];
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] reply with nothing pending: ok=%0b id=%h used=%0d",
                                 $realtime, got.ok, got.read_id, got.used);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.ok !== want.ok || got.read_id !== want.read_id ||
                        got.used !== want.used)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("[%0t] reply mismatch: exp ok=%0b id=%h used=%0d",
                                     $realtime, want.ok, want.read_id, want.used);
                            $display("    got ok=%0b id=%h used=%0d",
                                     got.ok, got.read_id, got.used);
                        end
                    end
                end
            end
        end
        else
            word_taken = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    logic [uat_pkg::ID_W-1:0] id_pool [POOL_SIZE];

    function automatic logic [uat_pkg::ID_W-1:0] pick_card();
        if ($urandom_range(0, 99) < 85)
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    initial
    begin
        int                        n_random;
        int                        segment;
        int                        start;
        int                        roll;
        bit                        fresh;
        logic [uat_pkg::ID_W-1:0]  cand;
        logic [uat_pkg::CMD_W-1:0] op;

        // ID pool: the two extremes plus distinct random IDs
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            fresh = 1'b0;
            while (!fresh)
            begin
                cand  = $urandom;
                fresh = 1'b1;
                for (int j = 0; j < i; j++)
                    if (id_pool[j] == cand)
                        fresh = 1'b0;
            end
            id_pool[i] = cand;
        end

        // directed part: empty list, extremes, duplicate add, compaction at
        // head and tail, bad indexes, spare codes, clear
        queue_word(uat_pkg::CMD_LOOKUP, 32'h0000_0000, 5'd0);   // empty list
        queue_word(uat_pkg::CMD_READ,   32'h0000_0000, 5'd0);   // read on empty list
        queue_word(uat_pkg::CMD_REMOVE, 32'h0000_0000, 5'd0);   // remove absent
        queue_word(uat_pkg::CMD_ADD,    32'h0000_0000, 5'd31);
        queue_word(uat_pkg::CMD_ADD,    32'hFFFF_FFFF, 5'd0);
        queue_word(uat_pkg::CMD_ADD,    32'hFFFF_FFFF, 5'd0);   // already present
        queue_word(uat_pkg::CMD_ADD,    32'h8000_0001, 5'd0);
        queue_word(uat_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 5'd0);
        queue_word(uat_pkg::CMD_LOOKUP, 32'h1234_5678, 5'd0);   // absent
        queue_word(uat_pkg::CMD_READ,   32'hFFFF_FFFF, 5'd1);
        queue_word(uat_pkg::CMD_READ,   32'h0000_0000, 5'd2);
        queue_word(uat_pkg::CMD_READ,   32'h0000_0000, 5'd3);   // index equal to count
        queue_word(uat_pkg::CMD_READ,   32'h0000_0000, 5'd31);  // far out of range
        queue_word(uat_pkg::CMD_REMOVE, 32'h0000_0000, 5'd0);   // head, rest shifts down
        queue_word(uat_pkg::CMD_READ,   32'h0000_0000, 5'd0);
        queue_word(uat_pkg::CMD_REMOVE, 32'h8000_0001, 5'd0);   // tail
        queue_word(uat_pkg::CMD_REMOVE, 32'h8000_0001, 5'd0);   // now absent
        queue_word(CMD_SPARE_FIRST, 32'hFFFF_FFFF, 5'd31);
        queue_word(CMD_SPARE_FIRST + 3'd1, 32'h0000_0000, 5'd0);
        queue_word(CMD_SPARE_LAST, 32'hA5A5_5A5A, 5'd15);
        queue_word(uat_pkg::CMD_CLEAR,  32'hFFFF_FFFF, 5'd31);
        queue_word(uat_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 5'd0);   // gone after clear
        queue_word(uat_pkg::CMD_READ,   32'h0000_0000, 5'd0);
        queue_word(uat_pkg::CMD_ADD,    32'h5A5A_A5A5, 5'd31);

        // random part in segments; the first one always fills the list
        n_random = 0;
        segment  = 0;
        while (n_random < RANDOM_GOAL)
        begin
            roll = (segment == 0) ? 0 : $urandom_range(0, 3);
            if (roll == 0)
            begin
                // fill: clear, then distinct adds past capacity, then poke it
                queue_word(uat_pkg::CMD_CLEAR, $urandom, 5'($urandom));
                start = $urandom_range(0, POOL_SIZE - 1);
                for (int i = 0; i < uat_pkg::CAPACITY + 2; i++)
                    queue_word(uat_pkg::CMD_ADD, id_pool[(start + i) % POOL_SIZE],
                               5'($urandom));
                for (int i = 0; i < 8; i++)
                    queue_word(uat_pkg::CMD_READ, $urandom, 5'($urandom));
                for (int i = 0; i < 4; i++)
                    queue_word(uat_pkg::CMD_REMOVE, pick_card(), 5'($urandom));
                for (int i = 0; i < 3; i++)
                    queue_word(uat_pkg::CMD_ADD, pick_card(), 5'($urandom));
                n_random += uat_pkg::CAPACITY + 18;
            end
            else if (roll == 3)
            begin
                // noise: any code, any ID, any index
                for (int i = 0; i < 10; i++)
                    queue_word(3'($urandom), $urandom, 5'($urandom));
                n_random += 10;
            end
            else
            begin
                // well-formed mix over the pool
                for (int i = 0; i < 30; i++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 25)
                        op = uat_pkg::CMD_LOOKUP;
                    else if (roll < 52)
                        op = uat_pkg::CMD_ADD;
                    else if (roll < 72)
                        op = uat_pkg::CMD_REMOVE;
                    else if (roll < 93)
                        op = uat_pkg::CMD_READ;
                    else if (roll < 96)
                        op = uat_pkg::CMD_CLEAR;
                    else
                        op = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
                    queue_word(op, pick_card(), 5'($urandom));
                end
                n_random += 30;
            end
            segment++;
        end

        total_words = pending_words.size();

        // wait for every word to be taken and every reply to come back
        @(posedge clk);
        while (pending_words.size() > 0 || words_taken < total_words ||
               expected_replies.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && expected_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/uat_pkg.sv
hw/rtl/uat_cell.sv
hw/rtl/uat_ring.sv
hw/rtl/uid_allowlist_table_top.sv
tb/sv/testbench.sv
